FILE: design/mbrtu_pkg.sv
// Shared types and constants for the Modbus RTU read-holding-registers master.
package mbrtu_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_WORD   = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BUSY      = 3'd1,
    ST_BAD_PARAM = 3'd2,
    ST_TIMEOUT   = 3'd3,
    ST_CRC_ERROR = 3'd4,
    ST_EXCEPTION = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    EX_IDLE,
    EX_CRC,
    EX_TXOUT,
    EX_WORDS,
    EX_STAT
  } exec_state_t;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FUNC_READ  = 8'h03;
  localparam logic [7:0]  FUNC_EXC   = 8'h83;
  localparam logic [7:0]  EXC_BIT    = 8'h80;
  localparam logic [7:0]  FUNC_MASK  = 8'h7F;
  localparam logic [6:0]  EXC_LEN    = 7'd5;

  // Item handed from the front to the back.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  slave_id;
    logic [15:0] start_register;
    logic [7:0]  register_count;
    logic [15:0] timeout_ticks;
    logic [7:0]  rx_data;
    logic        bad;
  } fitem_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] data_word;
    status_t     status;
    logic        last;
  } res_t;

endpackage

FILE: design/modbus_rtu_read_holding_master_top.sv
// Modbus RTU master, function 0x03: issues the request frame and decodes the reply.
// Each start, received byte or tick item is queued by the 2-entry front queue, then run by the
// back one at a time. A received byte is taken and then folded into the bit-serial CRC; the
// byte that completes a reply then outputs its register words if the reply is good, and
// always the status. An accepted start runs the CRC over the request and then outputs the
// request frame; a rejected start or a tick that times out outputs a status, and any other
// tick or byte while idle is only taken. Output stalls while the 2-entry result queue is full.
module modbus_rtu_read_holding_master_top #(
  parameter int MAX_REGISTERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_slave_id,
  input  logic [15:0] in_start_register,
  input  logic [7:0]  in_register_count,
  input  logic [15:0] in_timeout_ticks,
  input  logic [7:0]  in_rx_data,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  out_kind,
  output logic [15:0] out_data_word,
  output logic [2:0]  out_status,
  output logic        out_last
);
  mbrtu_pkg::fitem_t fin, qitem;
  mbrtu_pkg::res_t   res, rout;
  logic qv, qt, rv, rr;

  always_comb begin
    fin.cmd            = mbrtu_pkg::cmd_t'(in_command);
    fin.slave_id       = in_slave_id;
    fin.start_register = in_start_register;
    fin.register_count = in_register_count;
    fin.timeout_ticks  = in_timeout_ticks;
    fin.rx_data        = in_rx_data;
    fin.bad            = 1'b0;
  end

  mbrtu_front #(.MAX_REGISTERS(MAX_REGISTERS)) u_front (
    .clk, .rst_n, .push, .full, .item_in(fin),
    .q_valid(qv), .q_take(qt), .q_item(qitem)
  );

  mbrtu_back #(.MAX_REGISTERS(MAX_REGISTERS)) u_back (
    .clk, .rst_n, .q_valid(qv), .q_take(qt), .q_item(qitem),
    .res_valid(rv), .res_ready(rr), .res(res)
  );

  mbrtu_outq u_outq (
    .clk, .rst_n, .wr_valid(rv), .wr_ready(rr), .wr_data(res),
    .empty, .pop, .rd_data(rout)
  );

  assign out_kind      = rout.kind;
  assign out_data_word = rout.data_word;
  assign out_status    = rout.status;
  assign out_last      = rout.last;
endmodule

FILE: design/mbrtu_front.sv
// Front stage: classifies items and queues them for the back stage.
module mbrtu_front #(
  parameter int MAX_REGISTERS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  mbrtu_pkg::fitem_t   item_in,
  output logic                q_valid,
  input  logic                q_take,
  output mbrtu_pkg::fitem_t   q_item
);
  mbrtu_pkg::fitem_t mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  mbrtu_pkg::fitem_t cls;
  logic do_push, do_pop;

  always_comb begin
    cls = item_in;
    cls.bad = (item_in.slave_id == 8'd0) || (item_in.register_count == 8'd0) ||
              ({1'b0, item_in.register_count} > 9'(MAX_REGISTERS));
  end

  assign full    = (cnt_r == 2'd2);
  assign do_push = push && !full;
  assign q_valid = (cnt_r != 2'd0);
  assign do_pop  = q_take && q_valid;
  assign q_item  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= cls;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end
endmodule

FILE: design/mbrtu_back.sv
// Back stage: protocol state, bit-serial CRC, register store, result sequencing.
module mbrtu_back #(
  parameter int MAX_REGISTERS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_take,
  input  mbrtu_pkg::fitem_t q_item,
  output logic              res_valid,
  input  logic              res_ready,
  output mbrtu_pkg::res_t   res
);
  localparam int CW = $clog2(MAX_REGISTERS + 1);
  localparam int IW = (MAX_REGISTERS > 1) ? $clog2(MAX_REGISTERS) : 1;

  mbrtu_pkg::exec_state_t st_r, st_nxt;
  mbrtu_pkg::fitem_t it_r;
  logic        busy_r;
  logic [7:0]  slave_r;
  logic [CW-1:0] reqcnt_r;
  logic [6:0]  exp_r, rcv_r;
  logic [15:0] elap_r, tlim_r, crc_r, wcrc_r;
  logic [7:0]  func_r, bcnt_r, hi_r;
  logic        smatch_r;
  logic [15:0] store_r [MAX_REGISTERS];
  logic [15:0] rd_r;
  logic [2:0]  bit_r;
  logic [2:0]  byte_r;   // tx byte index / crc byte index
  logic [CW-1:0] widx_r;
  mbrtu_pkg::status_t fst_r;
  logic        judge_r;

  logic [7:0] tx_byte;
  logic [15:0] crc_in, crc_step;
  logic [15:0] nelap;
  logic [7:0] ncount8;

  always_comb begin
    case (byte_r)
      3'd0: tx_byte = it_r.slave_id;
      3'd1: tx_byte = mbrtu_pkg::FUNC_READ;
      3'd2: tx_byte = it_r.start_register[15:8];
      3'd3: tx_byte = it_r.start_register[7:0];
      3'd4: tx_byte = 8'd0;
      3'd5: tx_byte = it_r.register_count;
      3'd6: tx_byte = wcrc_r[7:0];
      default: tx_byte = wcrc_r[15:8];
    endcase
  end

  // one CRC bit per cycle; byte xor at bit 0
  always_comb begin
    crc_in   = (bit_r == 3'd0) ?
               (wcrc_r ^ {8'd0, (it_r.cmd == mbrtu_pkg::CMD_START) ? tx_byte : it_r.rx_data})
               : wcrc_r;
    crc_step = crc_in[0] ? ((crc_in >> 1) ^ mbrtu_pkg::CRC_POLY) : (crc_in >> 1);
  end

  assign nelap   = (elap_r == 16'hFFFF) ? elap_r : elap_r + 16'd1;
  assign ncount8 = 8'({reqcnt_r, 1'b0});

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      mbrtu_pkg::EX_IDLE: begin
        if (q_valid) begin
          case (q_item.cmd)
            mbrtu_pkg::CMD_START: st_nxt = (q_item.bad || busy_r) ?
                                           mbrtu_pkg::EX_STAT : mbrtu_pkg::EX_CRC;
            mbrtu_pkg::CMD_BYTE:  st_nxt = busy_r ? mbrtu_pkg::EX_CRC : mbrtu_pkg::EX_IDLE;
            mbrtu_pkg::CMD_TICK:  st_nxt = (busy_r && nelap >= tlim_r) ?
                                           mbrtu_pkg::EX_STAT : mbrtu_pkg::EX_IDLE;
            default: st_nxt = mbrtu_pkg::EX_IDLE;
          endcase
        end
      end
      mbrtu_pkg::EX_CRC: begin
        if (bit_r == 3'd7) begin
          if (it_r.cmd == mbrtu_pkg::CMD_START) begin
            if (byte_r == 3'd5) st_nxt = mbrtu_pkg::EX_TXOUT;
          end else if (judge_r) begin
            st_nxt = mbrtu_pkg::EX_WORDS;
          end else begin
            st_nxt = mbrtu_pkg::EX_IDLE;
          end
        end
      end
      mbrtu_pkg::EX_TXOUT:
        if (res_ready && byte_r == 3'd7) st_nxt = mbrtu_pkg::EX_IDLE;
      mbrtu_pkg::EX_WORDS:
        if (fst_r != mbrtu_pkg::ST_OK || widx_r == reqcnt_r) st_nxt = mbrtu_pkg::EX_STAT;
      mbrtu_pkg::EX_STAT:
        if (res_ready) st_nxt = mbrtu_pkg::EX_IDLE;
      default: st_nxt = mbrtu_pkg::EX_IDLE;
    endcase
  end

  logic word_out;
  assign word_out = (st_r == mbrtu_pkg::EX_WORDS) && (fst_r == mbrtu_pkg::ST_OK) &&
                    (widx_r != reqcnt_r);

  always_comb begin
    q_take    = (st_r == mbrtu_pkg::EX_IDLE) && q_valid;
    res_valid = 1'b0;
    res       = '0;
    case (st_r)
      mbrtu_pkg::EX_TXOUT: begin
        res_valid     = 1'b1;
        res.kind      = mbrtu_pkg::KIND_TX;
        res.data_word = {8'd0, tx_byte};
        res.last      = (byte_r == 3'd7);
      end
      mbrtu_pkg::EX_WORDS: begin
        res_valid     = word_out;
        res.kind      = mbrtu_pkg::KIND_WORD;
        res.data_word = rd_r;
      end
      mbrtu_pkg::EX_STAT: begin
        res_valid  = 1'b1;
        res.kind   = mbrtu_pkg::KIND_STATUS;
        res.status = fst_r;
        res.last   = 1'b1;
      end
      default: ;
    endcase
  end

  logic [6:0] idx;
  assign idx = rcv_r;

  always_ff @(posedge clk) begin
    // registered store read, advanced as words are taken
    if (st_r == mbrtu_pkg::EX_CRC || (word_out && res_ready))
      rd_r <= store_r[IW'((word_out && res_ready) ? widx_r + CW'(1) : CW'(0))];
    if (!rst_n) begin
      st_r <= mbrtu_pkg::EX_IDLE;
      busy_r <= 1'b0; slave_r <= '0; reqcnt_r <= '0; exp_r <= '0; rcv_r <= '0;
      elap_r <= '0; tlim_r <= '0; crc_r <= mbrtu_pkg::CRC_INIT; func_r <= '0;
      bcnt_r <= '0; hi_r <= '0; smatch_r <= 1'b0; bit_r <= '0; byte_r <= '0;
      widx_r <= '0; fst_r <= mbrtu_pkg::ST_OK; judge_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      case (st_r)
        mbrtu_pkg::EX_IDLE: if (q_valid) begin
          it_r   <= q_item;
          bit_r  <= '0;
          byte_r <= '0;
          widx_r <= '0;
          wcrc_r <= (q_item.cmd == mbrtu_pkg::CMD_START) ? mbrtu_pkg::CRC_INIT : crc_r;
          case (q_item.cmd)
            mbrtu_pkg::CMD_START:
              fst_r <= q_item.bad ? mbrtu_pkg::ST_BAD_PARAM : mbrtu_pkg::ST_BUSY;
            mbrtu_pkg::CMD_BYTE: if (busy_r) begin
              if (rcv_r == 7'd0) smatch_r <= (q_item.rx_data == slave_r);
              else if (rcv_r == 7'd1) begin
                func_r <= q_item.rx_data;
                if (q_item.rx_data == mbrtu_pkg::FUNC_EXC) exp_r <= mbrtu_pkg::EXC_LEN;
              end else if (rcv_r == 7'd2) bcnt_r <= q_item.rx_data;
              else if (idx + 7'd2 < exp_r) begin
                if (idx[0]) hi_r <= q_item.rx_data;   // off even <=> idx odd
                else if (7'(({1'b0, idx} - 8'd3) >> 1) < 7'(MAX_REGISTERS))
                  store_r[IW'((idx - 7'd3) >> 1)] <= {hi_r, q_item.rx_data};
              end
              rcv_r   <= idx + 7'd1;
              judge_r <= (idx + 7'd1 >= ((rcv_r == 7'd1 && q_item.rx_data ==
                         mbrtu_pkg::FUNC_EXC) ? mbrtu_pkg::EXC_LEN : exp_r));
            end
            mbrtu_pkg::CMD_TICK: if (busy_r) begin
              elap_r <= nelap;
              if (nelap >= tlim_r) begin
                busy_r <= 1'b0;
                fst_r  <= mbrtu_pkg::ST_TIMEOUT;
              end
            end
            default: ;
          endcase
        end
        mbrtu_pkg::EX_CRC: begin
          wcrc_r <= crc_step;
          bit_r  <= bit_r + 3'd1;
          if (bit_r == 3'd7) begin
            if (it_r.cmd == mbrtu_pkg::CMD_START) begin
              byte_r <= (byte_r == 3'd5) ? 3'd0 : byte_r + 3'd1;
              if (byte_r == 3'd5) begin
                busy_r <= 1'b1; slave_r <= it_r.slave_id;
                reqcnt_r <= CW'(it_r.register_count);
                exp_r <= 7'd5 + {it_r.register_count[5:0], 1'b0};
                rcv_r <= '0; elap_r <= '0; tlim_r <= it_r.timeout_ticks;
                crc_r <= mbrtu_pkg::CRC_INIT; func_r <= '0; bcnt_r <= '0;
                hi_r <= '0; smatch_r <= 1'b0;
              end
            end else begin
              crc_r <= crc_step;
              if (judge_r) begin
                busy_r <= 1'b0;
                if (crc_step != 16'd0) fst_r <= mbrtu_pkg::ST_CRC_ERROR;
                else if (!smatch_r || (func_r & mbrtu_pkg::FUNC_MASK) != mbrtu_pkg::FUNC_READ ||
                         (func_r & mbrtu_pkg::EXC_BIT) != 8'd0 || bcnt_r != ncount8)
                  fst_r <= mbrtu_pkg::ST_EXCEPTION;
                else fst_r <= mbrtu_pkg::ST_OK;
              end
            end
          end
        end
        mbrtu_pkg::EX_TXOUT: if (res_ready) byte_r <= byte_r + 3'd1;
        mbrtu_pkg::EX_WORDS: if (word_out && res_ready) widx_r <= widx_r + CW'(1);
        default: ;
      endcase
    end
  end
endmodule

FILE: design/mbrtu_outq.sv
// Output queue holding result items until popped.
module mbrtu_outq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  mbrtu_pkg::res_t wr_data,
  output logic            empty,
  input  logic            pop,
  output mbrtu_pkg::res_t rd_data
);
  mbrtu_pkg::res_t mem_r [2];
  logic [1:0] cnt_r;
  logic wp_r, rp_r, do_w, do_r;

  assign wr_ready = (cnt_r != 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_w     = wr_valid && wr_ready;
  assign do_r     = pop && !empty;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_w) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (do_w) wp_r <= ~wp_r;
      if (do_r) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(do_w) - 2'(do_r);
    end
  end
endmodule

FILE: design/mbrtu_checker.sv
// Port-level checks for the Modbus RTU master.
module mbrtu_props (
  input logic        clk,
  input logic        rst_n,
  input logic        empty,
  input logic [1:0]  out_kind,
  input logic [15:0] out_data_word,
  input logic [2:0]  out_status,
  input logic        out_last
);
  a_stat_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == mbrtu_pkg::KIND_STATUS) |-> out_last) else $error("status not last");
  a_stat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == mbrtu_pkg::KIND_STATUS) |-> out_data_word == 16'd0)
    else $error("status data nonzero");
  a_word_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind != mbrtu_pkg::KIND_STATUS) |-> out_status == mbrtu_pkg::ST_OK)
    else $error("data item with status");
  a_word_notlast: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == mbrtu_pkg::KIND_WORD) |-> !out_last) else $error("word marked last");
endmodule

bind modbus_rtu_read_holding_master_top mbrtu_props u_chk (
  .clk, .rst_n, .empty, .out_kind, .out_data_word, .out_status, .out_last
);

FILE: bench/mbrtu_checker.sv
// Checker: watches the request and result channels, predicts the master's results and compares.
module mbrtu_checker
  import mbrtu_pkg::*;
#(
  parameter int MAX_REGISTERS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_slave_id,
  input  logic [15:0] in_start_register,
  input  logic [7:0]  in_register_count,
  input  logic [15:0] in_timeout_ticks,
  input  logic [7:0]  in_rx_data,
  input  logic        empty,
  input  logic        pop,
  input  logic [1:0]  out_kind,
  input  logic [15:0] out_data_word,
  input  logic [2:0]  out_status,
  input  logic        out_last,
  output int          fail_count,
  output int          pending,
  output int          words_seen,
  output int          status_seen [6]
);
  timeunit 1ns;
  timeprecision 1ps;

  res_t        expected_q[$];
  logic        m_busy;
  logic [7:0]  m_slave;
  logic [7:0]  m_count;
  logic [6:0]  m_expect_len;
  logic [6:0]  m_rcvd;
  logic [15:0] m_elapsed;
  logic [15:0] m_limit;
  logic [15:0] m_crc;
  logic [7:0]  m_func;
  logic [7:0]  m_bytecount;
  logic [7:0]  m_high;
  logic        m_slave_ok;
  logic [15:0] m_regs [MAX_REGISTERS];

  assign pending = expected_q.size();

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void push_result(kind_t k, logic [15:0] w, status_t s, logic l);
    res_t r;
    r.kind = k;
    r.data_word = w;
    r.status = s;
    r.last = l;
    expected_q.push_back(r);
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count++;
  endtask

  task automatic finish_reply();
    status_t st;
    m_busy = 1'b0;
    if (m_crc != 16'h0000) st = ST_CRC_ERROR;
    else if (!m_slave_ok || (m_func & FUNC_MASK) != FUNC_READ) st = ST_EXCEPTION;
    else if ((m_func & EXC_BIT) != 8'h00) st = ST_EXCEPTION;
    else if (m_bytecount != 8'(m_count * 2)) st = ST_EXCEPTION;
    else st = ST_OK;
    if (st == ST_OK)
      for (int i = 0; i < m_count && i < MAX_REGISTERS; i++)
        push_result(KIND_WORD, m_regs[i], ST_OK, 1'b0);
    push_result(KIND_STATUS, 16'h0000, st, 1'b1);
  endtask

  task automatic predict_start();
    logic [7:0]  frame [8];
    logic [15:0] crc;
    if (in_slave_id == 8'h00 || in_register_count == 8'h00 ||
        in_register_count > MAX_REGISTERS) begin
      push_result(KIND_STATUS, 16'h0000, ST_BAD_PARAM, 1'b1);
      return;
    end
    if (m_busy) begin
      push_result(KIND_STATUS, 16'h0000, ST_BUSY, 1'b1);
      return;
    end
    frame[0] = in_slave_id;
    frame[1] = FUNC_READ;
    frame[2] = in_start_register[15:8];
    frame[3] = in_start_register[7:0];
    frame[4] = 8'h00;
    frame[5] = in_register_count;
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) crc = crc_update(crc, frame[i]);
    frame[6] = crc[7:0];
    frame[7] = crc[15:8];
    m_slave = in_slave_id;
    m_count = in_register_count;
    m_expect_len = 7'(5 + 2 * in_register_count);
    m_rcvd = '0;
    m_elapsed = '0;
    m_limit = in_timeout_ticks;
    m_crc = CRC_INIT;
    m_func = '0;
    m_bytecount = '0;
    m_high = '0;
    m_slave_ok = 1'b0;
    m_busy = 1'b1;
    for (int i = 0; i < 8; i++)
      push_result(KIND_TX, {8'h00, frame[i]}, ST_OK, i == 7);
  endtask

  task automatic predict_byte(logic [7:0] b);
    int idx;
    int off;
    if (!m_busy) return;
    idx = m_rcvd;
    m_crc = crc_update(m_crc, b);
    if (idx == 0) m_slave_ok = (b == m_slave);
    else if (idx == 1) begin
      m_func = b;
      if (b == FUNC_EXC) m_expect_len = EXC_LEN;
    end else if (idx == 2) m_bytecount = b;
    else if (idx + 2 < m_expect_len) begin
      off = idx - 3;
      if (off % 2 == 0) m_high = b;
      else if (off / 2 < MAX_REGISTERS) m_regs[off / 2] = {m_high, b};
    end
    m_rcvd = 7'(idx + 1);
    if (m_rcvd >= m_expect_len) finish_reply();
  endtask

  task automatic predict_tick();
    if (!m_busy) return;
    if (m_elapsed != 16'hFFFF) m_elapsed++;
    if (m_elapsed >= m_limit) begin
      m_busy = 1'b0;
      push_result(KIND_STATUS, 16'h0000, ST_TIMEOUT, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      m_busy <= 1'b0;
      m_rcvd <= '0;
      m_crc <= CRC_INIT;
      fail_count <= 0;
      words_seen <= 0;
      for (int i = 0; i < 6; i++) status_seen[i] <= 0;
      for (int i = 0; i < MAX_REGISTERS; i++) m_regs[i] <= '0;
    end else begin
      if (pop && !empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t result with none expected", $realtime);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (out_kind != want.kind) report("kind", out_kind, want.kind);
          if (out_data_word != want.data_word) report("data_word", out_data_word, want.data_word);
          if (out_status != want.status) report("status", out_status, want.status);
          if (out_last != want.last) report("last", out_last, want.last);
          if (want.kind == KIND_WORD) words_seen++;
          if (want.kind == KIND_STATUS) status_seen[want.status]++;
        end
      end
      if (push && !full) begin
        case (cmd_t'(in_command))
          CMD_START: predict_start();
          CMD_BYTE:  predict_byte(in_rx_data);
          CMD_TICK:  predict_tick();
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: bench/tb_top.sv
// Testbench top: drives requests, reply bytes and ticks into the Modbus master and gives the verdict.
module tb_top;
  import mbrtu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXR = 16;
  localparam int WATCHDOG = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  in_command = CMD_NONE;
  logic [7:0]  in_slave_id = '0;
  logic [15:0] in_start_register = '0;
  logic [7:0]  in_register_count = '0;
  logic [15:0] in_timeout_ticks = '0;
  logic [7:0]  in_rx_data = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  out_kind;
  logic [15:0] out_data_word;
  logic [2:0]  out_status;
  logic        out_last;
  int          fail_count;
  int          pending;
  int          words_seen;
  int          status_seen [6];
  int          sent = 0;
  int          idle_cycles = 0;
  bit          no_stall = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  modbus_rtu_read_holding_master_top #(.MAX_REGISTERS(MAXR)) u_dut (.*);

  mbrtu_checker #(.MAX_REGISTERS(MAXR)) u_check (.*);

  // item in flight on the input side
  logic [1:0]  n_cmd;
  logic [7:0]  n_slave, n_count, n_rx;
  logic [15:0] n_addr, n_tmo;

  task automatic send_item();
    while (!no_stall && $urandom_range(99) < 22) @(negedge clk);
    push = 1'b1;
    in_command <= n_cmd;
    in_slave_id <= n_slave;
    in_start_register <= n_addr;
    in_register_count <= n_count;
    in_timeout_ticks <= n_tmo;
    in_rx_data <= n_rx;
    do @(posedge clk); while (full);
    @(negedge clk);
    push = 1'b0;
    sent++;
  endtask

  task automatic item(logic [1:0] c, logic [7:0] s = 8'h11, logic [15:0] a = 16'h0000,
                      logic [7:0] n = 8'd1, logic [15:0] t = 16'd1000, logic [7:0] r = 8'h00);
    n_cmd = c; n_slave = s; n_addr = a; n_count = n; n_tmo = t; n_rx = r;
    send_item();
  endtask

  function automatic logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    crc ^= {8'h00, b};
    for (int i = 0; i < 8; i++) crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
    return crc;
  endfunction

  // reply frame: flaw 0 clean, 1 bad crc, 2 wrong slave, 3 exception, 4 bad count, 5 bad func
  task automatic send_reply(logic [7:0] slave, int cnt, int flaw);
    logic [7:0]  b [$];
    logic [15:0] crc;
    b.push_back(flaw == 2 ? slave ^ 8'h01 : slave);
    if (flaw == 3) begin
      b.push_back(FUNC_EXC);
      b.push_back(8'($urandom_range(1, 4)));
    end else begin
      b.push_back(flaw == 5 ? 8'h04 : FUNC_READ);
      b.push_back(flaw == 4 ? 8'(2 * cnt + 2) : 8'(2 * cnt));
      for (int i = 0; i < 2 * cnt; i++) b.push_back(8'($urandom));
    end
    crc = CRC_INIT;
    foreach (b[i]) crc = crc_step(crc, b[i]);
    if (flaw == 1) crc ^= 16'h0100;
    b.push_back(crc[7:0]);
    b.push_back(crc[15:8]);
    foreach (b[i]) item(CMD_BYTE, .r(b[i]));
  endtask

  task automatic transaction();
    logic [7:0] s;
    logic [15:0] tmo;
    int cnt, mode;
    s = 8'($urandom_range(1, 255));
    cnt = ($urandom_range(9) == 0) ? MAXR : $urandom_range(1, 4);
    mode = $urandom_range(99);
    tmo = (mode >= 80 && mode < 90) ? 16'($urandom_range(0, 6)) :
                                      16'($urandom_range(3, 60000));
    item(CMD_START, s, 16'($urandom), 8'(cnt), tmo);
    if (mode < 8) item(CMD_START, 8'($urandom_range(1, 255)), 16'($urandom), 8'd2);
    if (mode < 55) send_reply(s, cnt, 0);
    else if (mode < 80) send_reply(s, cnt, $urandom_range(1, 5));
    else if (mode < 90) begin
      // timeout with a small limit
      item(CMD_START, 8'h00, .n(8'd1));
      while (pending != 0) @(negedge clk);
      for (int i = 0; i < 10 && pending == 0; i++) item(CMD_TICK);
    end else begin
      // noise: random bytes, ticks and unknown commands
      repeat ($urandom_range(1, 4)) item(2'($urandom_range(1, 3)), .r(8'($urandom)));
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed
    item(CMD_START, 8'h00, 16'h0000, 8'd1);
    item(CMD_START, 8'h01, 16'hFFFF, 8'd0);
    item(CMD_START, 8'hFF, 16'h1234, 8'd17);
    item(CMD_START, 8'hFF, 16'h1234, 8'hFF);
    item(CMD_BYTE, .r(8'hAA));
    item(CMD_TICK);
    item(CMD_NONE, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 8'hFF);
    item(CMD_START, 8'hFF, 16'hFFFF, 8'd16, 16'hFFFF);
    item(CMD_START, 8'h01, 16'h0000, 8'd1);
    send_reply(8'hFF, 16, 0);
    item(CMD_START, 8'h01, 16'h0000, 8'd1, 16'd0);
    item(CMD_TICK);
    item(CMD_START, 8'h01, 16'h8000, 8'd2, 16'd2);
    item(CMD_TICK);
    item(CMD_TICK);
    item(CMD_START, 8'h7F, 16'h00FF, 8'd1);
    send_reply(8'h7F, 1, 3);
    item(CMD_START, 8'h80, 16'h0F0F, 8'd2);
    send_reply(8'h80, 2, 1);
    // drain before random traffic
    while (pending != 0) @(negedge clk);
    no_stall = 1'b1;
    repeat (6) transaction();
    no_stall = 1'b0;
    while (sent < 230) begin
      transaction();
      if ($urandom_range(19) == 0) while (pending != 0) @(negedge clk);
    end
    // final start with slave 0, answered with a bad-parameter status
    item(CMD_START, 8'h00);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("sent %0d items; %0d register words", sent, words_seen);
    $display("status ok/busy/bad/timeout/crc/exc = %0d/%0d/%0d/%0d/%0d/%0d",
             status_seen[0], status_seen[1], status_seen[2],
             status_seen[3], status_seen[4], status_seen[5]);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // result side: random pop with a stall-free stretch early on
  always @(negedge clk) begin
    if (!rst_n) pop <= 1'b0;
    else pop <= no_stall || ($urandom_range(99) >= 22);
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end
endmodule

FILE: sim.f
design/mbrtu_pkg.sv
design/mbrtu_front.sv
design/mbrtu_back.sv
design/mbrtu_outq.sv
design/modbus_rtu_read_holding_master_top.sv
design/mbrtu_checker.sv
bench/mbrtu_checker.sv
bench/tb_top.sv
